@@ hw/rtl/tst_pkg.sv @@
`default_nettype none

package tst_pkg;

    localparam int LINE_BITS = 31;
    localparam int LINE_FIELD_W = 31;
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QCNT_FULL = QUEUE_DEPTH[QPTR_W:0];

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TOKEN   = 3'd1;
    localparam logic [2:0] ERR_END     = 3'd2;
    localparam logic [2:0] ERR_INCLUDE = 3'd3;
    localparam logic [2:0] ERR_LINES   = 3'd4;

    typedef enum logic [2:0] {
        MODE_TOP,
        MODE_RUN,
        MODE_CMD,
        MODE_EXP,
        MODE_COM
    } mode_t;

    typedef enum logic [3:0] {
        TOK_NEED,
        TOK_NONE,
        TOK_LIT,
        TOK_CMD,
        TOK_EXP,
        TOK_COM,
        TOK_INCL,
        TOK_ESCO,
        TOK_ESCC,
        TOK_CLOSE,
        TOK_END
    } tok_t;

    typedef enum logic {
        FR_IDLE,
        FR_SCAN
    } front_state_t;

    // "printf %s " or "printf %s '"
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_EXP,
        PFX_RUN
    } pfx_t;

    typedef enum logic [2:0] {
        BODY_NONE,
        BODY_CH,
        BODY_QUOTE,
        BODY_ESCO,
        BODY_ESCC,
        BODY_NL
    } body_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_ERR,
        TERM_DONE
    } term_t;

    // One token's worth of output: "'\n" prefix, printf prefix, body, status row.
    typedef struct packed {
        logic                 quote_nl;
        pfx_t                 pfx;
        body_t                body;
        logic [7:0]           ch;
        term_t                term;
        logic [2:0]           code;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    byte_valid;
        logic                    last_of_run;
        logic [2:0]              error_code;
        logic [LINE_FIELD_W-1:0] error_line;
        logic                    done_res;
    } row_t;

    function automatic logic [4:0] job_len(input job_t j);
        logic [4:0] n;
        n = j.quote_nl ? 5'd2 : 5'd0;
        case (j.pfx)
            PFX_EXP: n = n + 5'd10;
            PFX_RUN: n = n + 5'd11;
            default: n = n;
        endcase
        case (j.body)
            BODY_CH, BODY_NL:     n = n + 5'd1;
            BODY_QUOTE:           n = n + 5'd4;
            BODY_ESCO, BODY_ESCC: n = n + 5'd2;
            default:              n = n;
        endcase
        if (j.term != TERM_NONE) begin
            n = n + 5'd1;
        end
        return n;
    endfunction

    function automatic logic [7:0] printf_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0:    c = "p";
            4'd1:    c = "r";
            4'd2:    c = "i";
            4'd3:    c = "n";
            4'd4:    c = "t";
            4'd5:    c = "f";
            4'd6:    c = " ";
            4'd7:    c = "%";
            4'd8:    c = "s";
            4'd9:    c = " ";
            4'd10:   c = CH_QUOTE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic row_t job_row(input job_t j, input logic [3:0] idx);
        row_t       r;
        logic [4:0] la;
        logic [4:0] lp;
        logic [4:0] lb;
        logic [4:0] pos;
        logic [4:0] k;
        r = '0;
        la = j.quote_nl ? 5'd2 : 5'd0;
        case (j.pfx)
            PFX_EXP: lp = 5'd10;
            PFX_RUN: lp = 5'd11;
            default: lp = 5'd0;
        endcase
        case (j.body)
            BODY_CH, BODY_NL:     lb = 5'd1;
            BODY_QUOTE:           lb = 5'd4;
            BODY_ESCO, BODY_ESCC: lb = 5'd2;
            default:              lb = 5'd0;
        endcase
        pos = {1'b0, idx};
        k = 5'd0;
        if (pos < la) begin
            r.byte_valid = 1'b1;
            r.out_byte = pos[0] ? CH_NL : CH_QUOTE;
        end else if (pos < la + lp) begin
            k = pos - la;
            r.byte_valid = 1'b1;
            r.out_byte = printf_char(k[3:0]);
        end else if (pos < la + lp + lb) begin
            k = pos - la - lp;
            r.byte_valid = 1'b1;
            case (j.body)
                BODY_CH:    r.out_byte = j.ch;
                BODY_QUOTE: r.out_byte = (k[1:0] == 2'd1) ? CH_BSL : CH_QUOTE;
                BODY_ESCO:  r.out_byte = k[0] ? CH_PCT : CH_LT;
                BODY_ESCC:  r.out_byte = k[0] ? CH_GT : CH_PCT;
                BODY_NL:    r.out_byte = CH_NL;
                default:    r.out_byte = 8'h00;
            endcase
        end else begin
            case (j.term)
                TERM_ERR:
                begin
                    r.error_code = j.code;
                    r.error_line[LINE_BITS-1:0] = j.line;
                end
                TERM_DONE: r.done_res = 1'b1;
                default:   r.done_res = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tst_in_if.sv @@
`default_nettype none

interface tst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink (input valid, input in_byte, input is_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tst_out_if.sv @@
`default_nettype none

interface tst_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic [2:0]  error_code;
    logic [30:0] error_line;
    logic        done_res;

    modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                    output error_code, output error_line, output done_res, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
                  input error_code, input error_line, input done_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tst_front.sv @@
`default_nettype none

module tst_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tst_in_if.sink        in_chan,
    output logic          push,
    output tst_pkg::job_t push_job,
    input  wire logic     q_full
);

    tst_pkg::front_state_t state_reg, state_next;
    tst_pkg::mode_t        mode_reg, mode_next;
    logic [7:0]            held_reg [3];
    logic [7:0]            held_next [3];
    logic [1:0]            held_cnt_reg, held_cnt_next;
    logic                  eat_reg, eat_next;
    logic [tst_pkg::LINE_BITS-1:0] line_reg, line_next;
    logic                  halted_reg, halted_next;
    logic                  is_end_reg, is_end_next;
    logic                  err4_reg, err4_next;
    logic [4:0]            used_reg, used_next;
    tst_pkg::job_t         pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;

    tst_pkg::tok_t  tok;
    logic [1:0]     take;
    logic           set_eat;
    logic           clr_eat;
    logic           has1, has2, has3;
    logic           c_special;

    tst_pkg::job_t  tjob;
    tst_pkg::job_t  err_job;
    tst_pkg::mode_t tmode;
    tst_pkg::body_t lit_body;
    tst_pkg::body_t run_body;
    logic           thalt;
    logic           top_rest;
    logic           lit_like;
    logic [4:0]     tcnt;
    logic [4:0]     limit;
    logic [1:0]     nl_left;
    logic           overflow;
    logic           stop;
    logic           has_res;
    logic           push_last;

    // Token recognition over the held bytes, up to two bytes of lookahead
    always_comb
    begin
        tok = tst_pkg::TOK_NEED;
        take = 2'd0;
        set_eat = 1'b0;
        clr_eat = 1'b0;
        has1 = (held_cnt_reg != 2'd0);
        has2 = (held_cnt_reg >= 2'd2);
        has3 = (held_cnt_reg == 2'd3);
        c_special = (held_reg[0] == tst_pkg::CH_LT) || (held_reg[0] == tst_pkg::CH_PCT) ||
                    (held_reg[0] == tst_pkg::CH_DASH);
        if (eat_reg) begin
            if (has1 || is_end_reg) begin
                clr_eat = 1'b1;
                tok = tst_pkg::TOK_CLOSE;
                if (has1 && held_reg[0] == tst_pkg::CH_NL) begin
                    take = 2'd1;
                end
            end
        end else if (!has1) begin
            tok = is_end_reg ? tst_pkg::TOK_END : tst_pkg::TOK_NEED;
        end else if (!c_special) begin
            tok = tst_pkg::TOK_LIT;
            take = 2'd1;
        end else if (!has2 && !is_end_reg) begin
            tok = tst_pkg::TOK_NEED;
        end else if (held_reg[0] == tst_pkg::CH_PCT && has2 && held_reg[1] == tst_pkg::CH_GT) begin
            tok = tst_pkg::TOK_CLOSE;
            take = 2'd2;
        end else if (!(has2 && held_reg[1] == tst_pkg::CH_PCT)) begin
            tok = tst_pkg::TOK_LIT;
            take = 2'd1;
        end else if (!has3 && !is_end_reg) begin
            tok = tst_pkg::TOK_NEED;
        end else if (held_reg[0] == tst_pkg::CH_LT) begin
            tok = tst_pkg::TOK_CMD;
            take = 2'd2;
            if (has3) begin
                case (held_reg[2])
                    tst_pkg::CH_EQ:
                    begin
                        tok = tst_pkg::TOK_EXP;
                        take = 2'd3;
                    end
                    tst_pkg::CH_PLUS:
                    begin
                        tok = tst_pkg::TOK_INCL;
                        take = 2'd3;
                    end
                    tst_pkg::CH_BANG:
                    begin
                        tok = tst_pkg::TOK_COM;
                        take = 2'd3;
                    end
                    tst_pkg::CH_PCT:
                    begin
                        tok = tst_pkg::TOK_ESCO;
                        take = 2'd3;
                    end
                    default:
                    begin
                        tok = tst_pkg::TOK_CMD;
                        take = 2'd2;
                    end
                endcase
            end
        end else if (has3 && held_reg[2] == tst_pkg::CH_GT) begin
            take = 2'd3;
            if (held_reg[0] == tst_pkg::CH_PCT) begin
                tok = tst_pkg::TOK_ESCC;
            end else begin
                // dash close: nothing yet, the following newline is eaten
                tok = tst_pkg::TOK_NONE;
                set_eat = 1'b1;
            end
        end else begin
            tok = tst_pkg::TOK_LIT;
            take = 2'd1;
        end
    end

    // Newlines still held once the token is taken; they do not count for the error line
    always_comb
    begin
        nl_left = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) >= take && 2'(i) < held_cnt_reg && held_reg[i] == tst_pkg::CH_NL) begin
                nl_left = nl_left + 2'd1;
            end
        end
    end

    // What the token produces in the current mode
    always_comb
    begin
        tjob = '0;
        tjob.pfx = tst_pkg::PFX_NONE;
        tjob.body = tst_pkg::BODY_NONE;
        tjob.term = tst_pkg::TERM_NONE;
        tjob.ch = held_reg[0];
        tjob.code = tst_pkg::ERR_NONE;
        tjob.line = line_reg - {{(tst_pkg::LINE_BITS-2){1'b0}}, nl_left};
        tmode = mode_reg;
        thalt = 1'b0;
        top_rest = 1'b0;
        lit_like = (tok == tst_pkg::TOK_LIT) || (tok == tst_pkg::TOK_ESCO) ||
                   (tok == tst_pkg::TOK_ESCC);
        if (tok == tst_pkg::TOK_ESCO) begin
            lit_body = tst_pkg::BODY_ESCO;
        end else if (tok == tst_pkg::TOK_ESCC) begin
            lit_body = tst_pkg::BODY_ESCC;
        end else begin
            lit_body = tst_pkg::BODY_CH;
        end
        run_body = (tok == tst_pkg::TOK_LIT && held_reg[0] == tst_pkg::CH_QUOTE) ?
                   tst_pkg::BODY_QUOTE : lit_body;
        if (tok != tst_pkg::TOK_NONE && tok != tst_pkg::TOK_NEED) begin
            case (mode_reg)
                tst_pkg::MODE_RUN:
                begin
                    if (lit_like) begin
                        tjob.body = run_body;
                    end else begin
                        tjob.quote_nl = 1'b1;
                        tmode = tst_pkg::MODE_TOP;
                        top_rest = 1'b1;
                    end
                end
                tst_pkg::MODE_CMD, tst_pkg::MODE_EXP:
                begin
                    if (lit_like) begin
                        tjob.body = lit_body;
                    end else begin
                        tjob.body = tst_pkg::BODY_NL;
                        if (tok == tst_pkg::TOK_CLOSE) begin
                            tmode = tst_pkg::MODE_TOP;
                        end else begin
                            tjob.term = tst_pkg::TERM_ERR;
                            tjob.code = (tok == tst_pkg::TOK_END) ? tst_pkg::ERR_END :
                                                                    tst_pkg::ERR_TOKEN;
                            thalt = 1'b1;
                        end
                    end
                end
                tst_pkg::MODE_COM:
                begin
                    if (!lit_like) begin
                        if (tok == tst_pkg::TOK_CLOSE) begin
                            tmode = tst_pkg::MODE_TOP;
                        end else begin
                            tjob.term = tst_pkg::TERM_ERR;
                            tjob.code = (tok == tst_pkg::TOK_END) ? tst_pkg::ERR_END :
                                                                    tst_pkg::ERR_TOKEN;
                            thalt = 1'b1;
                        end
                    end
                end
                tst_pkg::MODE_TOP:
                begin
                    if (lit_like) begin
                        tjob.pfx = tst_pkg::PFX_RUN;
                        tjob.body = run_body;
                        tmode = tst_pkg::MODE_RUN;
                    end else begin
                        top_rest = 1'b1;
                    end
                end
                default: tmode = tst_pkg::MODE_TOP;
            endcase
            if (top_rest) begin
                case (tok)
                    tst_pkg::TOK_CMD: tmode = tst_pkg::MODE_CMD;
                    tst_pkg::TOK_EXP:
                    begin
                        tjob.pfx = tst_pkg::PFX_EXP;
                        tmode = tst_pkg::MODE_EXP;
                    end
                    tst_pkg::TOK_COM: tmode = tst_pkg::MODE_COM;
                    tst_pkg::TOK_END:
                    begin
                        tjob.term = tst_pkg::TERM_DONE;
                        thalt = 1'b1;
                    end
                    tst_pkg::TOK_INCL:
                    begin
                        tjob.term = tst_pkg::TERM_ERR;
                        tjob.code = tst_pkg::ERR_INCLUDE;
                        thalt = 1'b1;
                    end
                    default:
                    begin
                        tjob.term = tst_pkg::TERM_ERR;
                        tjob.code = tst_pkg::ERR_TOKEN;
                        thalt = 1'b1;
                    end
                endcase
            end
        end
        tcnt = tst_pkg::job_len(tjob);
    end

    always_comb
    begin
        err_job = '0;
        err_job.pfx = tst_pkg::PFX_NONE;
        err_job.body = tst_pkg::BODY_NONE;
        err_job.term = tst_pkg::TERM_ERR;
        err_job.code = tst_pkg::ERR_LINES;
        err_job.line = line_reg;
    end

    // A transaction may yield at most 16 rows; one fewer when the line error follows
    assign limit    = err4_reg ? 5'd15 : 5'd16;
    assign overflow = !is_end_reg && ((used_reg + tcnt) > limit);
    assign stop     = halted_reg || (tok == tst_pkg::TOK_NEED) || overflow;
    assign has_res  = (tcnt != 5'd0);

    always_comb
    begin
        push_job = pend_reg;
        push_job.last = push_last;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        held_next = held_reg;
        held_cnt_next = held_cnt_reg;
        eat_next = eat_reg;
        line_next = line_reg;
        halted_next = halted_reg;
        is_end_next = is_end_reg;
        err4_next = err4_reg;
        used_next = used_reg;
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        push = 1'b0;
        push_last = 1'b0;
        in_chan.ready = 1'b0;
        case (state_reg)
            tst_pkg::FR_IDLE: in_chan.ready = 1'b1;
            tst_pkg::FR_SCAN:
            begin
                if (stop && err4_reg) begin
                    if (!pend_valid_reg || !q_full) begin
                        push = pend_valid_reg;
                        pend_next = err_job;
                        pend_valid_next = 1'b1;
                        halted_next = 1'b1;
                        err4_next = 1'b0;
                    end
                end else if (stop) begin
                    // item finished: the held job carries the last-of-run mark
                    if (!pend_valid_reg || !q_full) begin
                        in_chan.ready = 1'b1;
                        push = pend_valid_reg;
                        push_last = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next = tst_pkg::FR_IDLE;
                    end
                end else begin
                    if (!(has_res && pend_valid_reg && q_full)) begin
                        push = has_res && pend_valid_reg;
                        if (has_res) begin
                            pend_next = tjob;
                            pend_valid_next = 1'b1;
                        end
                        mode_next = tmode;
                        if (thalt) begin
                            halted_next = 1'b1;
                        end
                        if (set_eat) begin
                            eat_next = 1'b1;
                        end
                        if (clr_eat) begin
                            eat_next = 1'b0;
                        end
                        case (take)
                            2'd1:
                            begin
                                held_next[0] = held_reg[1];
                                held_next[1] = held_reg[2];
                            end
                            2'd2: held_next[0] = held_reg[2];
                            default: held_next[0] = held_reg[0];
                        endcase
                        held_cnt_next = held_cnt_reg - take;
                        used_next = used_reg + tcnt;
                    end
                end
            end
            default: state_next = tst_pkg::FR_IDLE;
        endcase
        if (in_chan.valid && in_chan.ready && !halted_reg) begin
            state_next = tst_pkg::FR_SCAN;
            used_next = 5'd0;
            is_end_next = in_chan.is_end;
            err4_next = 1'b0;
            if (!in_chan.is_end) begin
                if (in_chan.in_byte == tst_pkg::CH_NL && line_reg == '1) begin
                    err4_next = 1'b1;
                end else begin
                    if (in_chan.in_byte == tst_pkg::CH_NL) begin
                        line_next = line_reg + tst_pkg::LINE_ONE;
                    end
                    if (held_cnt_reg != 2'd3) begin
                        held_next[held_cnt_reg] = in_chan.in_byte;
                        held_cnt_next = held_cnt_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= tst_pkg::FR_IDLE;
            mode_reg <= tst_pkg::MODE_TOP;
            held_cnt_reg <= 2'd0;
            eat_reg <= 1'b0;
            line_reg <= tst_pkg::LINE_ONE;
            halted_reg <= 1'b0;
            is_end_reg <= 1'b0;
            err4_reg <= 1'b0;
            used_reg <= 5'd0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            held_cnt_reg <= held_cnt_next;
            eat_reg <= eat_next;
            line_reg <= line_next;
            halted_reg <= halted_next;
            is_end_reg <= is_end_next;
            err4_reg <= err4_next;
            used_reg <= used_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/tst_queue.sv @@
`default_nettype none

module tst_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tst_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output tst_pkg::job_t       head,
    output logic                empty
);

    tst_pkg::job_t                 mem_reg [tst_pkg::QUEUE_DEPTH];
    logic [tst_pkg::QPTR_W-1:0]    wr_reg, wr_next;
    logic [tst_pkg::QPTR_W-1:0]    rd_reg, rd_next;
    logic [tst_pkg::QPTR_W:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == tst_pkg::QCNT_FULL);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tst_back.sv @@
`default_nettype none

module tst_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               pop,
    input  wire tst_pkg::job_t head,
    input  wire logic          empty,
    tst_out_if.source          out_chan
);

    tst_pkg::job_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [3:0]    idx_reg, idx_next;
    tst_pkg::row_t out_reg, row_next;
    logic          out_valid_reg, out_valid_next;

    logic [4:0]    cur_len;
    logic          at_end;
    logic          load;

    assign cur_len = tst_pkg::job_len(cur_reg);
    assign at_end  = ({1'b0, idx_reg} == (cur_len - 5'd1));
    assign load    = cur_valid_reg && (!out_valid_reg || out_chan.ready);
    assign pop     = !empty && (!cur_valid_reg || (load && at_end));

    always_comb
    begin
        row_next = tst_pkg::job_row(cur_reg, idx_reg);
        row_next.last_of_run = at_end && cur_reg.last;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_chan.ready) begin
            out_valid_next = 1'b0;
        end
        cur_valid_next = cur_valid_reg;
        idx_next = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next = 4'd0;
        end else if (load) begin
            if (at_end) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            idx_reg <= 4'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            cur_valid_reg <= cur_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= row_next;
        end
        if (pop) begin
            cur_reg <= head;
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.out_byte    = out_reg.out_byte;
    assign out_chan.byte_valid  = out_reg.byte_valid;
    assign out_chan.last_of_run = out_reg.last_of_run;
    assign out_chan.error_code  = out_reg.error_code;
    assign out_chan.error_line  = out_reg.error_line;
    assign out_chan.done_res    = out_reg.done_res;

endmodule

`default_nettype wire

@@ hw/rtl/template_to_shell_translator.sv @@
// Template to shell script translator.
// in_chan takes one template byte per transaction (is_end marks the end of
// the template); out_chan gives script bytes, error rows and the final done
// row, with last_of_run on the last row caused by an input transaction.
// The front scans held bytes one token per cycle while the queue has room,
// and turns each token into an output job; a four-entry job queue feeds
// the back, which expands a job into up to fifteen rows, one row per cycle
// while out_chan is ready, through an output register. A transaction holds
// in_chan until the front has scanned each token that the byte completes;
// a newline that overflows the line count also adds a line error job.
// A row passes the held bytes, the pending job, the queue, the current job
// and the output register; text expanding to many bytes backs up into the
// queue and then holds in_chan.ready low. When out_chan stalls, the output
// register holds its row and the queue absorbs jobs until full. After an
// error or done row, transactions are taken and dropped until reset. Reset
// empties the queue and the output register, sets the line count to one
// and returns to plain text mode.
`default_nettype none

module template_to_shell_translator (
    input  wire logic clk,
    input  wire logic rst_n,
    tst_in_if.sink    in_chan,
    tst_out_if.source out_chan
);

    logic          push;
    tst_pkg::job_t push_job;
    logic          q_full;
    logic          pop;
    tst_pkg::job_t head;
    logic          q_empty;

    tst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    tst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    tst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .out_chan (out_chan)
    );

endmodule

`default_nettype wire
